FILE: rtl/dvtm_pkg.sv
package dvtm_pkg;

	localparam int PORT_W = 16;
	localparam int OP_W   = 3;
	localparam int RIDX_W = 4;

	localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
	localparam logic [OP_W-1:0] OP_MERGE = 3'd2;
	localparam logic [OP_W-1:0] OP_LINK  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ  = 3'd4;

	typedef logic [PORT_W-1:0] port_t;

	typedef struct packed {
		port_t port;
		port_t cost;
	} entry_t;

	// compare results for one table entry against the search keys
	typedef struct packed {
		logic eq_key;
		logic gt_key;
		logic eq_from;
	} cmp_t;

	function automatic port_t sat_add(port_t a, port_t b);
		logic [PORT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PORT_W] ? '1 : s[PORT_W-1:0];
	endfunction

endpackage

FILE: rtl/dvtm_if.sv
interface dvtm_cmd_if import dvtm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	port_t               dest_port;
	port_t               cost;
	port_t               from_port;
	logic                last_entry;
	logic [RIDX_W-1:0]   read_index;

	modport source (output valid, operation, dest_port, cost, from_port, last_entry,
		read_index, input ready);
	modport sink (input valid, operation, dest_port, cost, from_port, last_entry,
		read_index, output ready);
endinterface

interface dvtm_rsp_if import dvtm_pkg::*; ();
	logic  valid;
	logic  ready;
	port_t entry_port;
	port_t entry_cost;
	logic  updated;
	logic  added;
	logic  should_broadcast;

	modport source (output valid, entry_port, entry_cost, updated, added, should_broadcast,
		input ready);
	modport sink (input valid, entry_port, entry_cost, updated, added, should_broadcast,
		output ready);
endinterface

FILE: rtl/dvtm_ram.sv
module dvtm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/dvtm_cmp.sv
module dvtm_cmp import dvtm_pkg::*; (
	input  port_t entry_port,
	input  port_t key,
	input  port_t from_port,
	output cmp_t  res
);

	assign res.eq_key  = (entry_port == key);
	assign res.gt_key  = (entry_port > key);
	assign res.eq_from = (entry_port == from_port);

endmodule

FILE: rtl/distance_vector_table_merge.sv
// Distance-vector routing table engine. Holds up to TABLE_ENTRIES (port, cost)
// entries sorted by ascending port in one RAM, and runs one item at a time
// under a small sequencer around a single entry compare unit; cmd.ready is
// high only while the sequencer is idle. Clear, load of port 0 and unused
// codes finish in the idle state; read does one RAM read; load, merge and
// link scan the whole table, one entry per cycle through the RAM read port,
// and an insert adds a shift of the entries above the insert point (one
// entry per cycle) before the new entry is written. Nothing clears the RAM:
// entries at or above the fill count read back as port 0, cost 0. The result
// register lets the next item be taken while a result waits; a new result
// waits in the final state until the old one is taken. The user must write
// local_port through cfg_we/cfg_data only while idle; the block itself does
// not enforce it.
module distance_vector_table_merge import dvtm_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  port_t        cfg_data,
	dvtm_cmd_if.sink     cmd,
	dvtm_rsp_if.source   rsp
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int XW = (CW > RIDX_W) ? CW : RIDX_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_INS    = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0]      state_q;

	// persistent block state
	port_t           local_q;
	logic [CW-1:0]   count_q;
	port_t           sender_q;
	logic            in_vec_q;
	logic            pend_upd_q;
	logic            pend_add_q;
	logic            has_bc_q;

	// latched item
	logic [OP_W-1:0] op_q;
	port_t           dport_q;
	port_t           cost_q;
	port_t           fport_q;
	port_t           key_q;
	logic            last_q;
	logic            first_q;
	logic            rd_ok_q;
	logic            link_upd_q;

	// scan state: issue index, then compare stage aligned with the registered RAM read data
	logic [CW-1:0]   iss_q;
	logic            chk_vld_s1;
	logic [IW-1:0]   chk_idx_s1;
	logic            hit_q;
	logic [IW-1:0]   hit_idx_q;
	port_t           hit_cost_q;
	logic            pos_fnd_q;
	logic [CW-1:0]   pos_q;

	// shift state: source index to read, destination written in the following cycle
	logic [CW-1:0]   sh_rd_q;
	logic            sh_vld_s1;
	logic [IW-1:0]   sh_dst_s1;
	port_t           ins_cost_q;

	// result register
	logic            rsp_vld_q;
	port_t           rsp_port_q;
	port_t           rsp_cost_q;
	logic            rsp_upd_q;
	logic            rsp_add_q;
	logic            rsp_bc_q;

	// RAM ports
	logic            ram_we;
	logic [IW-1:0]   ram_waddr;
	entry_t          ram_wdata;
	logic            ram_re;
	logic [IW-1:0]   ram_raddr;
	logic [2*PORT_W-1:0] ram_rdata_raw;
	entry_t          ram_rdata;

	cmp_t            cmp;
	logic            cmd_acc;
	logic [XW-1:0]   ridx_x;
	logic            iss_lt;
	logic            sh_go;
	logic [CW-1:0]   sh_src;
	logic            full;
	port_t           sum;
	logic            skip;
	logic            dec_merge_wr;
	logic            dec_merge_ins;
	logic            dec_link_wr;
	logic            need_rsp;
	logic            bc;

	dvtm_ram #(
		.WIDTH (2 * PORT_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	dvtm_cmp u_cmp (
		.entry_port (ram_rdata.port),
		.key        (key_q),
		.from_port  (fport_q),
		.res        (cmp)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign ridx_x    = XW'(cmd.read_index);

	assign iss_lt = (iss_q < count_q);
	assign sh_go  = (sh_rd_q > pos_q);
	assign sh_src = sh_rd_q - CW'(1);
	assign full   = (count_q == CW'(TABLE_ENTRIES));

	// merge decision: sender cost plus entry cost, saturated
	assign sum  = sat_add(sender_q, cost_q);
	assign skip = (dport_q == '0) || (dport_q == local_q);

	assign dec_merge_wr  = (state_q == S_DECIDE) && (op_q == OP_MERGE) && !skip && hit_q &&
		(sum < hit_cost_q);
	assign dec_merge_ins = (op_q == OP_MERGE) && !skip && !hit_q && !full;
	assign dec_link_wr   = (state_q == S_DECIDE) && (op_q == OP_LINK) && hit_q &&
		(hit_cost_q != cost_q);

	assign need_rsp = ((op_q == OP_MERGE) && last_q) || (op_q == OP_LINK) ||
		(op_q == OP_READ);
	assign bc = !has_bc_q || pend_upd_q;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_re    = cmd_acc && (cmd.operation == OP_READ);
				ram_raddr = ridx_x[IW-1:0];
			end
			S_SCAN: begin
				ram_re    = iss_lt;
				ram_raddr = iss_q[IW-1:0];
			end
			S_DECIDE: begin
				ram_we    = dec_merge_wr || dec_link_wr;
				ram_waddr = hit_idx_q;
				ram_wdata = '{port: key_q, cost: (dec_merge_wr ? sum : cost_q)};
			end
			S_SHIFT: begin
				ram_re    = sh_go;
				ram_raddr = sh_src[IW-1:0];
				ram_we    = sh_vld_s1;
				ram_waddr = sh_dst_s1;
				ram_wdata = ram_rdata;
			end
			S_INS: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[IW-1:0];
				ram_wdata = '{port: key_q, cost: ins_cost_q};
			end
			default: begin
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_q    <= cmd.operation;
			dport_q <= cmd.dest_port;
			cost_q  <= cmd.cost;
			fport_q <= cmd.from_port;
			last_q  <= cmd.last_entry;
			key_q   <= (cmd.operation == OP_LINK) ? cmd.from_port : cmd.dest_port;
			rd_ok_q <= (ridx_x < XW'(count_q));
			iss_q   <= '0;
			pos_q   <= count_q;
		end
		if (state_q == S_SCAN) begin
			chk_idx_s1 <= iss_q[IW-1:0];
			if (iss_lt) begin
				iss_q <= iss_q + CW'(1);
			end
			if (chk_vld_s1 && cmp.eq_key && !hit_q) begin
				hit_idx_q  <= chk_idx_s1;
				hit_cost_q <= ram_rdata.cost;
			end
			if (chk_vld_s1 && cmp.gt_key && !pos_fnd_q) begin
				pos_q <= CW'(chk_idx_s1);
			end
		end
		if (state_q == S_DECIDE) begin
			sh_rd_q    <= count_q;
			ins_cost_q <= (op_q == OP_MERGE) ? sum : cost_q;
		end
		if (state_q == S_SHIFT) begin
			sh_dst_s1 <= sh_rd_q[IW-1:0];
			if (sh_go) begin
				sh_rd_q <= sh_src;
			end
		end
		if ((state_q == S_FINISH) && need_rsp && (!rsp_vld_q || rsp.ready)) begin
			rsp_port_q <= (op_q == OP_READ && rd_ok_q) ? ram_rdata.port : '0;
			rsp_cost_q <= (op_q == OP_READ && rd_ok_q) ? ram_rdata.cost : '0;
			rsp_upd_q  <= (op_q == OP_MERGE) ? pend_upd_q :
				((op_q == OP_LINK) ? link_upd_q : 1'b0);
			rsp_add_q  <= (op_q == OP_MERGE) && pend_add_q;
			rsp_bc_q   <= (op_q == OP_MERGE) && bc;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			local_q    <= '0;
			count_q    <= '0;
			sender_q   <= '0;
			in_vec_q   <= 1'b0;
			pend_upd_q <= 1'b0;
			pend_add_q <= 1'b0;
			has_bc_q   <= 1'b0;
			first_q    <= 1'b0;
			link_upd_q <= 1'b0;
			chk_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			pos_fnd_q  <= 1'b0;
			sh_vld_s1  <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				local_q <= cfg_data;
			end
			if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					chk_vld_s1 <= 1'b0;
					hit_q      <= 1'b0;
					pos_fnd_q  <= 1'b0;
					if (cmd_acc) begin
						unique case (cmd.operation)
							OP_CLEAR: begin
								count_q    <= '0;
								has_bc_q   <= 1'b0;
								in_vec_q   <= 1'b0;
								pend_upd_q <= 1'b0;
								pend_add_q <= 1'b0;
							end
							OP_LOAD: begin
								if (cmd.dest_port != '0) begin
									state_q <= S_SCAN;
								end
							end
							OP_MERGE: begin
								first_q <= !in_vec_q;
								if (!in_vec_q) begin
									sender_q   <= '0;
									in_vec_q   <= 1'b1;
									pend_upd_q <= 1'b0;
									pend_add_q <= 1'b0;
								end
								state_q <= S_SCAN;
							end
							OP_LINK: begin
								link_upd_q <= 1'b0;
								state_q    <= S_SCAN;
							end
							OP_READ: begin
								state_q <= S_FINISH;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					chk_vld_s1 <= iss_lt;
					if (chk_vld_s1) begin
						if (cmp.eq_key) begin
							hit_q <= 1'b1;
						end
						if (cmp.gt_key) begin
							pos_fnd_q <= 1'b1;
						end
						// the sender cost is the last matching entry, not the first
						if ((op_q == OP_MERGE) && first_q && cmp.eq_from) begin
							sender_q <= ram_rdata.cost;
						end
					end
					if (!iss_lt && !chk_vld_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					sh_vld_s1 <= 1'b0;
					state_q   <= S_FINISH;
					if (op_q == OP_LOAD && !full) begin
						state_q <= S_SHIFT;
					end
					if (dec_merge_wr) begin
						pend_upd_q <= 1'b1;
					end
					if (dec_merge_ins) begin
						pend_add_q <= 1'b1;
						state_q    <= S_SHIFT;
					end
					if (dec_link_wr) begin
						link_upd_q <= 1'b1;
					end
				end
				S_SHIFT: begin
					sh_vld_s1 <= sh_go;
					if (!sh_go && !sh_vld_s1) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					count_q <= count_q + CW'(1);
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!need_rsp) begin
						state_q <= S_IDLE;
					end else if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q <= 1'b1;
						state_q   <= S_IDLE;
						if (op_q == OP_MERGE) begin
							in_vec_q <= 1'b0;
							if (bc) begin
								has_bc_q <= 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid            = rsp_vld_q;
	assign rsp.entry_port       = rsp_port_q;
	assign rsp.entry_cost       = rsp_cost_q;
	assign rsp.updated          = rsp_upd_q;
	assign rsp.added            = rsp_add_q;
	assign rsp.should_broadcast = rsp_bc_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("table written while idle");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && chk_vld_s1) |-> (CW'(chk_idx_s1) < count_q))
		else $error("scan compared an entry past the fill count");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> (count_q < CW'(TABLE_ENTRIES)))
		else $error("insert into a full table");
`endif

endmodule
